// ===== src/pqdo_pkg.sv =====
// Package for the drop-oldest packet queue: sizes, codes and small helpers.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pqdo_pkg;

    // Geometry of the slot ring
    localparam int SLOT_BYTES  = 64;
    localparam int QUEUE_DEPTH = 8;
    localparam int SLOTS       = QUEUE_DEPTH + 1;
    localparam int MEM_DEPTH   = SLOTS * SLOT_BYTES;

    // Derived widths
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ADDR_W  = $clog2(MEM_DEPTH);
    localparam int LEN_W   = $clog2(SLOT_BYTES);
    localparam int WLEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;
    localparam int CAP_W    = 7;
    localparam int BCNT_W   = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH       = 3'd0,
        ACT_TAKE       = 3'd1,
        ACT_CLEAR      = 3'd2,
        ACT_CONNECT    = 3'd3,
        ACT_DISCONNECT = 3'd4,
        ACT_TAKE_DISC  = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA        = 3'd0,
        ST_TAKEN_EMPTY = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_DISCARDED   = 3'd4,
        ST_DISC_ANSWER = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } t_state;

    // Ring successor of a slot index
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    // First byte address of a slot
    function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
        return ADDR_W'(s) * ADDR_W'(SLOT_BYTES);
    endfunction

endpackage

`default_nettype wire

// ===== src/pqdo_if.sv =====
// Valid/ready channel interfaces for the packet queue: command in, result out.
// Depends on pqdo_pkg for field widths.
`default_nettype none

interface pqdo_cmd_if import pqdo_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
    logic [CAP_W-1:0]    capacity;

    modport source (output valid, action, data_byte, last_byte, capacity, input ready);
    modport sink   (input valid, action, data_byte, last_byte, capacity, output ready);
endinterface

interface pqdo_res_if import pqdo_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic [BCNT_W-1:0]   byte_count;
    logic                disconnect_seen;
    logic                link_up;
    logic                last_result;

    modport source (output valid, status, out_byte, byte_count, disconnect_seen,
                    link_up, last_result, input ready);
    modport sink   (input valid, status, out_byte, byte_count, disconnect_seen,
                    link_up, last_result, output ready);
endinterface

`default_nettype wire

// ===== src/packet_queue_drop_oldest_top.sv =====
// Drop-oldest packet queue: byte store in one synchronous RAM, ring control.
// Depends on pqdo_pkg and the channel interfaces in pqdo_if.sv.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  i_cmd    | in  | valid / ready | action, data_byte, last_byte, capacity
//  o_res    | out | valid / ready | status, out_byte, byte_count,
//           |     |               | disconnect_seen, link_up, last_result
//
// A take of n bytes streams one byte per cycle, while the result channel is
// not stalled, out of the byte RAM (one read port, registered read data);
// single-answer takes give a single result.
// Reset is synchronous and clears all control state; the byte RAM and slot
// lengths need no clearing. A stalled result holds; the command side waits
// only while a result is held or a packet is streaming.
`default_nettype none

module packet_queue_drop_oldest_top import pqdo_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pqdo_cmd_if.sink   i_cmd,
    pqdo_res_if.source o_res
);

    // Control registers
    t_state                r_state,   n_state;
    logic [SLOT_W-1:0]     r_head,    n_head;
    logic [SLOT_W-1:0]     r_tail,    n_tail;
    logic [CNT_W-1:0]      r_count,   n_count;
    logic [WLEN_W-1:0]     r_wlen,    n_wlen;
    logic                  r_ovf,     n_ovf;
    logic                  r_disc,    n_disc;
    logic                  r_conn,    n_conn;
    logic [LEN_W-1:0]      r_idx,     n_idx;
    logic [LEN_W-1:0]      r_n,       n_n;
    logic [SLOT_W-1:0]     r_tslot,   n_tslot;
    logic                  r_ov,      n_ov;
    t_status               r_st,      n_st;
    logic [BCNT_W-1:0]     r_cnt,     n_cnt;
    logic                  r_seen,    n_seen;
    logic                  r_last,    n_last;

    // Storage
    logic [BYTE_W-1:0]     r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]     r_rd_data;
    logic [LEN_W-1:0]      r_slot_len [SLOTS];

    // Access strobes
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic                  len_we;

    logic                  out_free, cmd_acc;
    logic [WLEN_W-1:0]     wlen_after;
    logic                  push_stores;
    logic [CAP_W-1:0]      cap_m1, len_ext, n_full;
    logic [LEN_W-1:0]      take_n;

    assign out_free    = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // Push length bookkeeping
    assign push_stores = r_wlen < WLEN_W'(SLOT_BYTES);
    assign wlen_after  = push_stores ? r_wlen + WLEN_W'(1) : r_wlen;

    // Bytes to deliver: min(length, capacity - 1, SLOT_BYTES - 1)
    assign cap_m1  = i_cmd.capacity - CAP_W'(1);
    assign len_ext = CAP_W'(r_slot_len[r_tail]);
    always_comb begin
        n_full = (len_ext < cap_m1) ? len_ext : cap_m1;
        if (n_full > CAP_W'(SLOT_BYTES - 1)) begin
            n_full = CAP_W'(SLOT_BYTES - 1);
        end
        take_n = n_full[LEN_W-1:0];
    end

    // Next state and RAM access
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_wlen  = r_wlen;
        n_ovf   = r_ovf;
        n_disc  = r_disc;
        n_conn  = r_conn;
        n_idx   = r_idx;
        n_n     = r_n;
        n_tslot = r_tslot;
        n_ov    = r_ov && !o_res.ready;
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        n_last  = r_last;
        mem_we    = 1'b0;
        mem_waddr = slot_base(r_head) + ADDR_W'(r_wlen);
        mem_re    = 1'b0;
        mem_raddr = slot_base(r_tail);
        len_we    = 1'b0;

        if (r_state == S_STREAM) begin
            if (out_free) begin
                mem_re    = 1'b1;
                mem_raddr = slot_base(r_tslot) + ADDR_W'(r_idx);
                n_ov      = 1'b1;
                n_st      = ST_DATA;
                n_seen    = 1'b0;
                n_idx     = r_idx + LEN_W'(1);
                if (r_idx == r_n - LEN_W'(1)) begin
                    n_last  = 1'b1;
                    n_cnt   = BCNT_W'(r_n);
                    n_state = S_IDLE;
                end else begin
                    n_last  = 1'b0;
                    n_cnt   = '0;
                end
            end
        end else if (cmd_acc) begin
            case (t_action'(i_cmd.action))
                ACT_PUSH: begin
                    mem_we = push_stores;
                    n_wlen = wlen_after;
                    if (i_cmd.last_byte) begin
                        n_wlen = '0;
                        if (wlen_after >= WLEN_W'(SLOT_BYTES)) begin
                            n_ovf = 1'b1;
                        end else begin
                            len_we = 1'b1;
                            n_head = next_slot(r_head);
                            // full queue: oldest packet makes room
                            if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                                n_tail = next_slot(r_tail);
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                    end
                end
                ACT_TAKE: begin
                    n_ov   = 1'b1;
                    n_cnt  = '0;
                    n_seen = 1'b0;
                    n_last = 1'b1;
                    if (r_ovf) begin
                        n_ovf = 1'b0;
                        n_st  = ST_OVERFLOW;
                    end else if (r_count == '0) begin
                        n_st = ST_EMPTY;
                    end else begin
                        n_tail  = next_slot(r_tail);
                        n_count = r_count - CNT_W'(1);
                        if (i_cmd.capacity == '0) begin
                            n_st = ST_DISCARDED;
                        end else if (take_n == '0) begin
                            n_st = ST_TAKEN_EMPTY;
                        end else begin
                            // first byte read now, rest streamed
                            mem_re = 1'b1;
                            n_st   = ST_DATA;
                            if (take_n == LEN_W'(1)) begin
                                n_cnt = BCNT_W'(take_n);
                            end else begin
                                n_last  = 1'b0;
                                n_state = S_STREAM;
                                n_idx   = LEN_W'(1);
                                n_n     = take_n;
                                n_tslot = r_tail;
                            end
                        end
                    end
                end
                ACT_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_wlen  = '0;
                    n_ovf   = 1'b0;
                    n_disc  = 1'b0;
                end
                ACT_CONNECT: begin
                    n_conn = 1'b1;
                end
                ACT_DISCONNECT: begin
                    n_conn = 1'b0;
                    n_disc = 1'b1;
                end
                ACT_TAKE_DISC: begin
                    n_ov   = 1'b1;
                    n_st   = ST_DISC_ANSWER;
                    n_cnt  = '0;
                    n_seen = r_disc;
                    n_last = 1'b1;
                    n_disc = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_wlen  <= '0;
            r_ovf   <= 1'b0;
            r_disc  <= 1'b0;
            r_conn  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_wlen  <= n_wlen;
            r_ovf   <= n_ovf;
            r_disc  <= n_disc;
            r_conn  <= n_conn;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_tslot <= n_tslot;
        r_st    <= n_st;
        r_cnt   <= n_cnt;
        r_seen  <= n_seen;
        r_last  <= n_last;
    end

    // Byte RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_cmd.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Committed packet lengths
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_slot_len[r_head] <= wlen_after[LEN_W-1:0];
        end
    end

    // Result channel
    assign o_res.valid           = r_ov;
    assign o_res.status          = r_st;
    assign o_res.out_byte        = (r_st == ST_DATA) ? r_rd_data : '0;
    assign o_res.byte_count      = r_cnt;
    assign o_res.disconnect_seen = r_seen;
    assign o_res.link_up         = r_conn;
    assign o_res.last_result     = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("packet count above queue depth");

    a_wlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wlen <= WLEN_W'(SLOT_BYTES))
        else $error("write length beyond slot");

    a_stream_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> !i_cmd.ready)
        else $error("command taken during a stream");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_st == ST_DATA && r_last) |-> (r_cnt != '0))
        else $error("final data item with zero count");

    a_stream_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_STREAM && r_state == S_IDLE) |-> (r_ov && r_last))
        else $error("stream ended without final item");

endmodule

`default_nettype wire
